// File: rtl/core/bdhr_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce package
// Shared types, register indexes and reset values for the button debouncer.
// ---------------------------------------------------------------------------
`default_nettype none

package bdhr_pkg;

    localparam int CntWidth = 16;
    localparam int PcWidth  = 8;
    localparam int IdxWidth = 3;
    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;
    localparam int RemStepWidth = $clog2(CntWidth);

    localparam logic [CntWidth-1:0] TICK_MAX = {CntWidth{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PUSHED   = 2'd1,
        PH_RELEASED = 2'd2
    } phase_t;

    localparam logic [IdxWidth-1:0] REG_PRESS_CONFIRM   = 3'd0;
    localparam logic [IdxWidth-1:0] REG_LOCK_TIME       = 3'd1;
    localparam logic [IdxWidth-1:0] REG_REPEAT_START    = 3'd2;
    localparam logic [IdxWidth-1:0] REG_REPEAT_PERIOD   = 3'd3;
    localparam logic [IdxWidth-1:0] REG_LONG_PRESS_TIME = 3'd4;
    localparam logic [IdxWidth-1:0] REG_BEEP_TIME       = 3'd5;

    localparam logic [PcWidth-1:0]  PRESS_CONFIRM_RST   = 8'd7;
    localparam logic [CntWidth-1:0] LOCK_TIME_RST       = 16'd30;
    localparam logic [CntWidth-1:0] REPEAT_START_RST    = 16'd300;
    localparam logic [CntWidth-1:0] REPEAT_PERIOD_RST   = 16'd65;
    localparam logic [CntWidth-1:0] LONG_PRESS_TIME_RST = 16'd2000;
    localparam logic [CntWidth-1:0] BEEP_TIME_RST       = 16'd50;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

`default_nettype wire

// File: rtl/core/bdhr_rem_unit.sv
// ---------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle, that yields the remainder
// of the tick count by the repeat period.
// ---------------------------------------------------------------------------
`default_nettype none

module bdhr_rem_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bdhr_pkg::CntWidth-1:0] dividend,
    input  wire logic [bdhr_pkg::CntWidth-1:0] divisor,
    output bdhr_pkg::rem_status_t              status,
    output logic      [bdhr_pkg::CntWidth-1:0] remainder
);
    import bdhr_pkg::*;

    logic                    busy_reg, busy_next;
    logic [RemStepWidth-1:0] step_reg, step_next;
    logic [CntWidth-1:0]     dq_reg, dq_next;
    logic [CntWidth-1:0]     rem_reg, rem_next;
    logic [CntWidth:0]       trial;
    logic                    last_step;

    assign trial     = {rem_reg, dq_reg[CntWidth-1]};
    assign last_step = busy_reg && (step_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = RemStepWidth'(CntWidth - 1);
            dq_next   = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dq_next   = {dq_reg[CntWidth-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = CntWidth'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[CntWidth-1:0];
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = last_step && !start;
    assign remainder   = rem_next;

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_hold_repeat_unit.sv
// ---------------------------------------------------------------------------
// Button debounce with hold and auto-repeat
// One-button debouncer with press confirm, beep, hold, repeat and long-hold
// flags, and a lockout after release.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    level_released, wake, clear_repeat
//  out      out_valid / out_stall  phase_now, pressed_event, locked,
//                                  hold_reached, repeat_due, long_hold,
//                                  beep, busy_res
//  cfg      APB write/read         paddr, pwdata, prdata
//
// One word is accepted per clock while in_stall is low; its result is ready in
// the following cycle in the output register, which frees while the next word
// is being accepted. A write to repeat_period starts a remainder pass in the
// divider; in_stall stays high while that pass runs.
// rst_n clears all control state and loads the register reset values.
// in_stall also follows out_stall while a result waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module button_debounce_hold_repeat_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bdhr_pkg::AddrWidth-1:0] paddr,
    input  wire logic [bdhr_pkg::DataWidth-1:0] pwdata,
    output logic      [bdhr_pkg::DataWidth-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           level_released,
    input  wire logic                           wake,
    input  wire logic                           clear_repeat,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [1:0]                     phase_now,
    output logic                                pressed_event,
    output logic                                locked,
    output logic                                hold_reached,
    output logic                                repeat_due,
    output logic                                long_hold,
    output logic                                beep,
    output logic                                busy_res
);
    import bdhr_pkg::*;

    logic [PcWidth-1:0]  press_confirm_reg;
    logic [CntWidth-1:0] lock_time_reg;
    logic [CntWidth-1:0] repeat_start_reg;
    logic [CntWidth-1:0] repeat_period_reg;
    logic [CntWidth-1:0] long_press_time_reg;
    logic [CntWidth-1:0] beep_time_reg;

    logic                cfg_write;
    logic [IdxWidth-1:0] cfg_idx;

    logic                query_reg, query_next;
    phase_t              phase_reg, phase_next;
    logic [CntWidth-1:0] tick_reg, tick_next;
    logic [CntWidth-1:0] mod_reg, mod_next;
    logic                action_reg, action_next;
    logic                lock_reg, lock_next;
    logic                hold_reg, hold_next;
    logic                repeat_reg, repeat_next;
    logic                long_reg, long_next;
    logic                beep_reg, beep_next;

    logic                out_valid_reg;
    phase_t              out_phase_reg;
    logic                out_action_reg;
    logic                out_lock_reg;
    logic                out_hold_reg;
    logic                out_repeat_reg;
    logic                out_long_reg;
    logic                out_beep_reg;
    logic                out_query_reg;

    logic                in_accept;
    logic                out_free;
    logic [CntWidth-1:0] tick_inc;
    logic [CntWidth:0]   mod_inc;
    logic                rem_start;
    rem_status_t         rem_status;
    logic [CntWidth-1:0] rem_value;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[AddrWidth-1:2];
    assign pready    = 1'b1;
    assign rem_start = cfg_write && (cfg_idx == REG_REPEAT_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_confirm_reg   <= PRESS_CONFIRM_RST;
            lock_time_reg       <= LOCK_TIME_RST;
            repeat_start_reg    <= REPEAT_START_RST;
            repeat_period_reg   <= REPEAT_PERIOD_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
            beep_time_reg       <= BEEP_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PRESS_CONFIRM:   press_confirm_reg   <= pwdata[PcWidth-1:0];
                REG_LOCK_TIME:       lock_time_reg       <= pwdata[CntWidth-1:0];
                REG_REPEAT_START:    repeat_start_reg    <= pwdata[CntWidth-1:0];
                REG_REPEAT_PERIOD:   repeat_period_reg   <= pwdata[CntWidth-1:0];
                REG_LONG_PRESS_TIME: long_press_time_reg <= pwdata[CntWidth-1:0];
                REG_BEEP_TIME:       beep_time_reg       <= pwdata[CntWidth-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PRESS_CONFIRM:   prdata = DataWidth'(press_confirm_reg);
            REG_LOCK_TIME:       prdata = DataWidth'(lock_time_reg);
            REG_REPEAT_START:    prdata = DataWidth'(repeat_start_reg);
            REG_REPEAT_PERIOD:   prdata = DataWidth'(repeat_period_reg);
            REG_LONG_PRESS_TIME: prdata = DataWidth'(long_press_time_reg);
            REG_BEEP_TIME:       prdata = DataWidth'(beep_time_reg);
            default:             prdata = '0;
        endcase
    end

    // The remainder of the tick count by the new period is recomputed here.
    bdhr_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (tick_reg),
        .divisor   (repeat_period_reg),
        .status    (rem_status),
        .remainder (rem_value)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = rem_status.busy || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign tick_inc  = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    // The mod register tracks the pushed tick count modulo repeat_period.
    always_comb
    begin
        query_next  = query_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        mod_next    = mod_reg;
        action_next = action_reg;
        lock_next   = lock_reg;
        hold_next   = hold_reg;
        repeat_next = repeat_reg;
        long_next   = long_reg;
        beep_next   = beep_reg;
        mod_inc     = {1'b0, mod_reg} + 1'b1;

        if (rem_status.done)
        begin
            mod_next = (repeat_period_reg == '0) ? '0 : rem_value;
        end

        if (in_accept)
        begin
            if (wake)
            begin
                query_next = 1'b1;
            end
            if (clear_repeat)
            begin
                repeat_next = 1'b0;
            end
            if (query_next)
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!level_released)
                        begin
                            tick_next = tick_inc;
                        end
                        else if (tick_reg != '0)
                        begin
                            tick_next = tick_reg - 1'b1;
                        end
                        if (tick_next >= {{(CntWidth-PcWidth){1'b0}}, press_confirm_reg})
                        begin
                            action_next = 1'b1;
                            lock_next   = 1'b1;
                            phase_next  = PH_PUSHED;
                            tick_next   = '0;
                            mod_next    = '0;
                            beep_next   = 1'b1;
                        end
                        else if (tick_next == '0)
                        begin
                            action_next = 1'b0;
                            lock_next   = 1'b0;
                            query_next  = 1'b0;
                        end
                    end
                    PH_PUSHED:
                    begin
                        if (!level_released)
                        begin
                            tick_next = tick_inc;
                            if (repeat_period_reg == '0)
                            begin
                                mod_next = '0;
                            end
                            else if (tick_reg != TICK_MAX)
                            begin
                                mod_next = (mod_inc == {1'b0, repeat_period_reg}) ?
                                           '0 : mod_inc[CntWidth-1:0];
                            end
                        end
                        else
                        begin
                            tick_next  = '0;
                            mod_next   = '0;
                            phase_next = PH_RELEASED;
                        end
                        if (tick_next == beep_time_reg)
                        begin
                            beep_next = 1'b0;
                        end
                        if (tick_next == repeat_start_reg)
                        begin
                            hold_next = 1'b1;
                        end
                        if (hold_next && mod_next == '0)
                        begin
                            repeat_next = 1'b1;
                        end
                        if (tick_next >= long_press_time_reg)
                        begin
                            long_next = 1'b1;
                        end
                    end
                    PH_RELEASED:
                    begin
                        if (level_released)
                        begin
                            tick_next = tick_inc;
                        end
                        if (tick_next >= lock_time_reg)
                        begin
                            query_next  = 1'b0;
                            action_next = 1'b0;
                            lock_next   = 1'b0;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                            hold_next   = 1'b0;
                            repeat_next = 1'b0;
                            long_next   = 1'b0;
                            beep_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            mod_reg       <= '0;
            action_reg    <= 1'b0;
            lock_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            repeat_reg    <= 1'b0;
            long_reg      <= 1'b0;
            beep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            query_reg     <= query_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            mod_reg       <= mod_next;
            action_reg    <= action_next;
            lock_reg      <= lock_next;
            hold_reg      <= hold_next;
            repeat_reg    <= repeat_next;
            long_reg      <= long_next;
            beep_reg      <= beep_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_phase_reg  <= phase_next;
            out_action_reg <= action_next;
            out_lock_reg   <= lock_next;
            out_hold_reg   <= hold_next;
            out_repeat_reg <= repeat_next;
            out_long_reg   <= long_next;
            out_beep_reg   <= beep_next;
            out_query_reg  <= query_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase_now     = out_phase_reg;
    assign pressed_event = out_action_reg;
    assign locked        = out_lock_reg;
    assign hold_reached  = out_hold_reg;
    assign repeat_due    = out_repeat_reg;
    assign long_hold     = out_long_reg;
    assign beep          = out_beep_reg;
    assign busy_res      = out_query_reg;

endmodule

`default_nettype wire

// File: rtl/core/bdhr_checker.sv
// ---------------------------------------------------------------------------
// Button debounce checker
// Port-level checks on the result word and the configuration side effects.
// ---------------------------------------------------------------------------
`default_nettype none

module bdhr_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic [bdhr_pkg::AddrWidth-1:0] paddr,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [1:0]                     phase_now,
    input wire logic                           pressed_event,
    input wire logic                           locked,
    input wire logic                           hold_reached,
    input wire logic                           repeat_due,
    input wire logic                           long_hold,
    input wire logic                           beep,
    input wire logic                           busy_res
);
    import bdhr_pkg::*;

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phase_now)
            && $stable(repeat_due) && $stable(busy_res))
        else $error("result word changed while stalled");

    // Outside idle the press is locked and checking stays armed.
    a_active_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase_now != PH_IDLE) |-> locked && pressed_event && busy_res)
        else $error("active phase without lock or armed checking");

    // In idle none of the timing flags survive.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase_now == PH_IDLE)
            |-> !hold_reached && !repeat_due && !long_hold && !beep)
        else $error("timing flag set in idle");

    // Repeat only follows a reached hold.
    a_repeat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && repeat_due |-> hold_reached)
        else $error("repeat flag without hold flag");

    // A new repeat period blocks input while the remainder is recomputed.
    a_period_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[AddrWidth-1:2] == REG_REPEAT_PERIOD)
            |=> in_stall)
        else $error("input accepted during remainder pass");

endmodule

bind button_debounce_hold_repeat_unit bdhr_checker u_bdhr_checker (.*);

`default_nettype wire

// File: dv/button_debounce_hold_repeat_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button debouncer testbench
// Sends 1 ms tick words through the input channel under random bursts, gaps
// and output stalls. A behavioral debouncer model predicts the result words,
// but checked directed rows take theirs from a table. Register settings cover
// the reset values, all ones, all maximums, and random small settings with
// occasional extremes; a long output hold-off fills the block to stall input.
// ---------------------------------------------------------------------------

module button_debounce_hold_repeat_unit_tb;

    import bdhr_pkg::*;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_ITEMS = 900;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        phase_t ph;
        logic   act;
        logic   lck;
        logic   hold;
        logic   rpt;
        logic   lng;
        logic   bp;
        logic   busy;
    } tick_result_t;

    typedef struct packed {
        logic         rel;
        logic         wk;
        logic         clr;
        logic         checked;
        tick_result_t res;
    } dir_row_t;

    localparam tick_result_t IDLE_CLEAR = '{PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam tick_result_t IDLE_ARMED = '{PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam tick_result_t PUSH_START =
        '{PH_PUSHED, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam tick_result_t RELEASE_START =
        '{PH_RELEASED, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    // Rows run with the reset register values, so a press confirms after 7 net ticks.
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{1'b1, 1'b0, 1'b0, 1'b1, IDLE_CLEAR},
        '{1'b0, 1'b0, 1'b1, 1'b1, IDLE_CLEAR},
        '{1'b1, 1'b1, 1'b0, 1'b1, IDLE_CLEAR},
        '{1'b0, 1'b1, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b1, 1'b0, 1'b0, 1'b1, IDLE_CLEAR},
        '{1'b0, 1'b1, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b1, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b1, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, IDLE_ARMED},
        '{1'b0, 1'b0, 1'b0, 1'b1, PUSH_START},
        '{1'b0, 1'b0, 1'b1, 1'b1, PUSH_START},
        '{1'b0, 1'b1, 1'b0, 1'b0, PUSH_START},
        '{1'b1, 1'b0, 1'b0, 1'b1, RELEASE_START},
        '{1'b0, 1'b0, 1'b0, 1'b1, RELEASE_START},
        '{1'b1, 1'b0, 1'b1, 1'b0, RELEASE_START},
        '{1'b1, 1'b1, 1'b0, 1'b0, RELEASE_START}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [DataWidth-1:0] pwdata = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 level_released = 1'b1;
    logic                 wake = 1'b0;
    logic                 clear_repeat = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           phase_now;
    logic                 pressed_event;
    logic                 locked;
    logic                 hold_reached;
    logic                 repeat_due;
    logic                 long_hold;
    logic                 beep;
    logic                 busy_res;

    // Model copy of the registers.
    logic [PcWidth-1:0]  cfg_press = PRESS_CONFIRM_RST;
    logic [CntWidth-1:0] cfg_lock = LOCK_TIME_RST;
    logic [CntWidth-1:0] cfg_start = REPEAT_START_RST;
    logic [CntWidth-1:0] cfg_period = REPEAT_PERIOD_RST;
    logic [CntWidth-1:0] cfg_long = LONG_PRESS_TIME_RST;
    logic [CntWidth-1:0] cfg_beep = BEEP_TIME_RST;

    // Model copy of the debouncer state.
    logic                armed = 1'b0;
    phase_t              ph_st = PH_IDLE;
    logic [CntWidth-1:0] tick_cnt = '0;
    logic                act_f = 1'b0;
    logic                lock_f = 1'b0;
    logic                hold_f = 1'b0;
    logic                rpt_f = 1'b0;
    logic                long_f = 1'b0;
    logic                beep_f = 1'b0;

    tick_result_t expected_ticks [$];
    tick_result_t dir_exp;
    logic         dir_exp_valid = 1'b0;

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_settings = 0;
    int n_press = 0;
    int n_repeat = 0;
    int n_long = 0;
    int burst_left = 0;
    int holdoff_req = 0;

    button_debounce_hold_repeat_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .level_released (level_released),
        .wake           (wake),
        .clear_repeat   (clear_repeat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_now      (phase_now),
        .pressed_event  (pressed_event),
        .locked         (locked),
        .hold_reached   (hold_reached),
        .repeat_due     (repeat_due),
        .long_hold      (long_hold),
        .beep           (beep),
        .busy_res       (busy_res)
    );

    always #5 clk = ~clk;

    function automatic logic one_in(input int n);
        return $urandom_range(1, n) == 1;
    endfunction

    function automatic tick_result_t debounce_tick(input logic rel, input logic wk,
                                                   input logic clr);
        tick_result_t r;
        if (wk)
        begin
            armed = 1'b1;
        end
        if (clr)
        begin
            rpt_f = 1'b0;
        end
        if (armed)
        begin
            case (ph_st)
                PH_IDLE:
                begin
                    if (!rel)
                    begin
                        if (tick_cnt != TICK_MAX)
                        begin
                            tick_cnt = tick_cnt + 1'b1;
                        end
                    end
                    else if (tick_cnt != '0)
                    begin
                        tick_cnt = tick_cnt - 1'b1;
                    end
                    if (tick_cnt >= {8'd0, cfg_press})
                    begin
                        act_f = 1'b1;
                        lock_f = 1'b1;
                        ph_st = PH_PUSHED;
                        tick_cnt = '0;
                        beep_f = 1'b1;
                        n_press++;
                    end
                    else if (tick_cnt == '0)
                    begin
                        act_f = 1'b0;
                        lock_f = 1'b0;
                        armed = 1'b0;
                    end
                end
                PH_PUSHED:
                begin
                    if (!rel)
                    begin
                        if (tick_cnt != TICK_MAX)
                        begin
                            tick_cnt = tick_cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        tick_cnt = '0;
                        ph_st = PH_RELEASED;
                    end
                    if (tick_cnt == cfg_beep)
                    begin
                        beep_f = 1'b0;
                    end
                    if (tick_cnt == cfg_start)
                    begin
                        hold_f = 1'b1;
                    end
                    if (hold_f && (cfg_period == '0 || tick_cnt % cfg_period == '0))
                    begin
                        if (!rpt_f)
                        begin
                            n_repeat++;
                        end
                        rpt_f = 1'b1;
                    end
                    if (tick_cnt >= cfg_long)
                    begin
                        if (!long_f)
                        begin
                            n_long++;
                        end
                        long_f = 1'b1;
                    end
                end
                PH_RELEASED:
                begin
                    if (rel && tick_cnt != TICK_MAX)
                    begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                    if (tick_cnt >= cfg_lock)
                    begin
                        armed = 1'b0;
                        act_f = 1'b0;
                        lock_f = 1'b0;
                        ph_st = PH_IDLE;
                        tick_cnt = '0;
                        hold_f = 1'b0;
                        rpt_f = 1'b0;
                        long_f = 1'b0;
                        beep_f = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.ph = ph_st;
        r.act = act_f;
        r.lck = lock_f;
        r.hold = hold_f;
        r.rpt = rpt_f;
        r.lng = long_f;
        r.bp = beep_f;
        r.busy = armed;
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = debounce_tick(level_released, wake, clear_repeat);
                if (dir_exp_valid)
                begin
                    want = dir_exp;
                end
                expected_ticks.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result word with no input word pending", $time);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    n_checked++;
                    check_field("phase_now", want.ph, phase_now);
                    check_field("pressed_event", want.act, pressed_event);
                    check_field("locked", want.lck, locked);
                    check_field("hold_reached", want.hold, hold_reached);
                    check_field("repeat_due", want.rpt, repeat_due);
                    check_field("long_hold", want.lng, long_hold);
                    check_field("beep", want.bp, beep);
                    check_field("busy_res", want.busy, busy_res);
                end
            end
        end
    end

    // Receiver: the stall pattern is redrawn for each random-length segment; a hold-off
    // request keeps the output stalled long enough for the block to back up.
    initial
    begin
        int mode;
        int seg_left;
        int served;
        int hold_left;
        mode = 0;
        seg_left = 0;
        served = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (served != holdoff_req)
            begin
                served = holdoff_req;
                hold_left = HOLDOFF_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= one_in(4);
                    2: out_stall <= !one_in(4);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic send_word(input logic rel, input logic wk, input logic clr);
        int gap;
        if (burst_left == 0)
        begin
            gap = one_in(4) ? 0 : $urandom_range(1, 4);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        level_released <= rel;
        wake <= wk;
        clear_repeat <= clr;
        n_sent++;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_ticks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [CntWidth-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_PRESS_CONFIRM:   cfg_press = value[PcWidth-1:0];
            REG_LOCK_TIME:       cfg_lock = value;
            REG_REPEAT_START:    cfg_start = value;
            REG_REPEAT_PERIOD:   cfg_period = value;
            REG_LONG_PRESS_TIME: cfg_long = value;
            REG_BEEP_TIME:       cfg_beep = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== {16'd0, value})
        begin
            n_errors++;
            $display("%0t: readback of register %0d, expected %0d, got %0d",
                     $time, idx, value, prdata);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int p, input int l, input int s, input int r,
                              input int lg, input int b);
        drain();
        write_reg(REG_PRESS_CONFIRM, p[CntWidth-1:0]);
        write_reg(REG_LOCK_TIME, l[CntWidth-1:0]);
        write_reg(REG_REPEAT_START, s[CntWidth-1:0]);
        write_reg(REG_REPEAT_PERIOD, r[CntWidth-1:0]);
        write_reg(REG_LONG_PRESS_TIME, lg[CntWidth-1:0]);
        write_reg(REG_BEEP_TIME, b[CntWidth-1:0]);
        n_settings++;
    endtask

    // One press: wake, some contact bounce, the held stretch and the release
    // stretch. glitch_odds of 0 keeps the held and release stretches clean.
    task automatic press_cycle(input int hold_len, input int rel_len, input int glitch_odds);
        int i;
        send_word(1'b0, 1'b1, one_in(8));
        repeat ($urandom_range(0, 4)) send_word(1'($urandom_range(0, 1)), 1'b0, one_in(8));
        for (i = 0; i < hold_len; i++)
        begin
            send_word(glitch_odds != 0 && one_in(glitch_odds), 1'b0, one_in(8));
        end
        for (i = 0; i < rel_len; i++)
        begin
            send_word(!(glitch_odds != 0 && one_in(glitch_odds)), one_in(30), one_in(8));
        end
    endtask

    task automatic random_cycles(input int count);
        int hold_len;
        int rel_len;
        repeat (count)
        begin
            if (one_in(5))
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
            hold_len = one_in(4) ? $urandom_range(0, int'(cfg_press))
                                 : int'(cfg_press) + $urandom_range(0, 80);
            rel_len = $urandom_range(0, cfg_lock <= 16 ? int'(cfg_lock) + 6 : 24);
            press_cycle(hold_len, rel_len, 40);
        end
    endtask

    initial
    begin
        int i;
        int p;
        int l;
        int s;
        int r;
        int lg;
        int b;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            dir_exp_valid = DIRECTED[i].checked;
            dir_exp = DIRECTED[i].res;
            send_word(DIRECTED[i].rel, DIRECTED[i].wk, DIRECTED[i].clr);
        end
        dir_exp_valid = 1'b0;

        repeat (35) send_word(1'b1, 1'b0, 1'b0);
        press_cycle(int'(cfg_press) + 60, 40, 0);

        set_config(3, 4, 8, 3, 20, 5);
        random_cycles(2);
        holdoff_req++;
        random_cycles(4);

        set_config(1, 1, 1, 1, 1, 1);
        random_cycles(3);

        set_config(255, 65535, 65535, 65535, 65535, 65535);
        press_cycle(30, 5, 0);
        drain();
        write_reg(REG_PRESS_CONFIRM, 16'd1);
        press_cycle(40, 5, 0);
        drain();
        write_reg(REG_LOCK_TIME, 16'd2);
        repeat (5) send_word(1'b1, 1'b0, 1'b0);

        while (n_sent < NUM_ITEMS)
        begin
            p = $urandom_range(1, 8);
            l = $urandom_range(1, 10);
            s = $urandom_range(1, 20);
            r = $urandom_range(1, 8);
            lg = $urandom_range(1, 60);
            b = $urandom_range(1, 15);
            case ($urandom_range(0, 9))
                0: p = 255;
                1: l = 65535;
                2: s = 65535;
                3: r = 65535;
                4: lg = 65535;
                5: b = 65535;
                default:
                begin
                end
            endcase
            set_config(p, l, s, r, lg, b);
            random_cycles(2);
        end

        drain();
        repeat (10) @(negedge clk);
        $display("Run covered %0d words (%0d checked), %0d settings, %0d-cycle hold-off.",
                 n_sent, n_checked, n_settings, HOLDOFF_CYCLES);
        $display("Presses confirmed: %0d, repeat flags raised: %0d, long holds: %0d, mismatches: %0d.",
                 n_press, n_repeat, n_long, n_errors);
        if (n_errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d result words still expected.", expected_ticks.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
